// ===== sv/tbgs_pkg.sv =====
package tbgs_pkg;

	// Physical constants in Q16.16.
	localparam logic [19:0] GRAV_Q16    = 20'd642908;
	localparam logic [15:0] SPEED_K_Q16 = 16'd46989;
	localparam logic [33:0] DV_CAP      = 34'h200000000;

	// Configuration register indexes and their reset values.
	localparam logic [1:0] CFG_TIME_STEP     = 2'd0;
	localparam logic [1:0] CFG_CENTRAL_MASS  = 2'd1;
	localparam logic [1:0] CFG_ORBITING_MASS = 2'd2;

	localparam logic [15:0] TIME_STEP_RST = 16'd655;
	localparam logic [31:0] MASS_RST      = 32'd65536;

	// Input command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	typedef enum logic [1:0] {
		ALU_MUL  = 2'd0,
		ALU_DIV  = 2'd1,
		ALU_SQRT = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic       start;
		alu_op_t    op;
		logic       accum;
		logic [7:0] steps;
	} alu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic ovf;
	} alu_sts_t;

	typedef struct packed {
		logic               command;
		logic signed [31:0] central_x;
		logic signed [31:0] central_y;
		logic signed [31:0] central_z;
		logic signed [31:0] orbiting_x;
		logic signed [31:0] orbiting_y;
		logic signed [31:0] orbiting_z;
	} item_t;

	typedef struct packed {
		logic signed [31:0] central_pos_x;
		logic signed [31:0] central_pos_y;
		logic signed [31:0] central_pos_z;
		logic signed [31:0] orbiting_pos_x;
		logic signed [31:0] orbiting_pos_y;
		logic signed [31:0] orbiting_pos_z;
		logic        [31:0] separation;
		logic               degenerate;
	} result_t;

endpackage

// ===== sv/tbgs_alu.sv =====
module tbgs_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  tbgs_pkg::alu_ctl_t ctl,
	input  logic [127:0]       opa,
	input  logic [191:0]       opb,
	output tbgs_pkg::alu_sts_t sts,
	output logic [127:0]       res
);
	import tbgs_pkg::*;

	alu_op_t      op_q;
	logic         busy_q;
	logic         done_q;
	logic [7:0]   cnt_q;
	logic [127:0] acc_q;
	logic [191:0] sh_q;
	logic [63:0]  mp_q;
	logic         first_q;
	logic         ovf_q;

	logic [63:0]  root_trial;
	logic [191:0] sub_op;
	logic [192:0] diff;
	logic         ge;

	// One shared subtractor serves both the divider and the square root.
	always_comb begin
		root_trial = sh_q[63:0] + mp_q;
		sub_op     = (op_q == ALU_SQRT) ? {128'b0, root_trial} : sh_q;
		diff       = {65'b0, acc_q} - {1'b0, sub_op};
		ge         = ~diff[192];
	end

	// Iteration count and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q   <= ALU_MUL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
				op_q   <= ctl.op;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one multiplier bit, one quotient bit or one root bit per cycle.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			case (ctl.op)
				ALU_DIV: begin
					acc_q   <= opa;
					sh_q    <= opb;
					mp_q    <= '0;
					first_q <= 1'b1;
					ovf_q   <= 1'b0;
				end
				ALU_SQRT: begin
					acc_q <= opa;
					sh_q  <= '0;
					mp_q  <= 64'h4000_0000_0000_0000;
				end
				default: begin
					acc_q <= ctl.accum ? acc_q : '0;
					sh_q  <= {64'b0, opa};
					mp_q  <= opb[63:0];
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				ALU_DIV: begin
					if (ge) begin
						acc_q <= diff[127:0];
					end
					if (first_q && ge) begin
						ovf_q <= 1'b1;
					end
					first_q <= 1'b0;
					mp_q    <= {mp_q[62:0], ge};
					sh_q    <= sh_q >> 1;
				end
				ALU_SQRT: begin
					if (ge) begin
						acc_q <= diff[127:0];
						sh_q  <= {128'b0, (sh_q[63:0] >> 1) + mp_q};
					end else begin
						sh_q <= {128'b0, sh_q[63:0] >> 1};
					end
					mp_q <= mp_q >> 2;
				end
				default: begin
					if (mp_q[0]) begin
						acc_q <= acc_q + sh_q[127:0];
					end
					sh_q <= sh_q << 1;
					mp_q <= mp_q >> 1;
				end
			endcase
		end
	end

	always_comb begin
		case (op_q)
			ALU_DIV:  res = {64'b0, mp_q};
			ALU_SQRT: res = {64'b0, sh_q[63:0]};
			default:  res = acc_q;
		endcase
		sts.busy = busy_q;
		sts.done = done_q;
		sts.ovf  = ovf_q;
	end

	property p_no_start_busy;
		@(posedge clk) disable iff (!arst_n) ctl.start |-> !busy_q;
	endproperty
	a_no_start_busy: assert property (p_no_start_busy)
		else $error("shared unit started while busy");

	property p_done_ends_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q && $past(busy_q);
	endproperty
	a_done_ends_busy: assert property (p_done_ends_busy)
		else $error("completion without a running operation");

	property p_cnt_zero_idle;
		@(posedge clk) disable iff (!arst_n) busy_q |-> cnt_q != 8'd0;
	endproperty
	a_cnt_zero_idle: assert property (p_cnt_zero_idle)
		else $error("iteration count ran out while busy");

endmodule

// ===== sv/two_body_gravity_step_top.sv =====
// Two-body gravity stepper, semi-implicit Euler in signed Q16.16.
// Items arrive on item_valid/item_ready. Command load stores both positions
// and sets the starting z velocities; command step applies gravity for one
// time step. Each transfer in yields exactly one result transfer on
// result_valid/result_ready with both positions, the separation and a flag
// for zero separation (then the state is left as it was).
// Configuration (time step, both masses) is written through cfg_valid,
// cfg_index and cfg_data; cfg_ready is always high. Write only while idle.
// All arithmetic runs on one shared unit that multiplies, divides or takes
// a square root, one bit per cycle. A step item runs three 33-bit squares,
// a 32-bit root, d cubed, two mass products each times the time step, then
// six 33-bit products, six 35-bit divisions and six 16-bit products. A load
// item's work is dominated by two 65-bit divisions; a zero separation ends
// the item after the root. One item is worked on at a time; the next item
// is taken as soon as the result is in the output register, even if the
// receiver is still stalling it.
// Reset clears both bodies' positions and velocities and loads the
// configuration reset values; no result is pending after reset.
module two_body_gravity_step_top #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  tbgs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output tbgs_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [31:0]       cfg_data
);
	import tbgs_pkg::*;

	localparam int SPD_SH = 2 * FRAC_BITS - 16;
	localparam int DVN_SH = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
	localparam int DVD_SH = (2 * FRAC_BITS < 32) ? 32 - 2 * FRAC_BITS : 0;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_SQ    = 15'b000000000000010,
		S_ROOT  = 15'b000000000000100,
		S_CHK   = 15'b000000000001000,
		S_GM    = 15'b000000000010000,
		S_SDIV  = 15'b000000000100000,
		S_SROOT = 15'b000000001000000,
		S_SK    = 15'b000000010000000,
		S_DD    = 15'b000000100000000,
		S_DDD   = 15'b000001000000000,
		S_GMT   = 15'b000010000000000,
		S_MR    = 15'b000100000000000,
		S_DIV   = 15'b001000000000000,
		S_ADV   = 15'b010000000000000,
		S_OUT   = 15'b100000000000000
	} state_t;

	function automatic logic [32:0] mag33(input logic [32:0] v);
		return v[32] ? (~v + 33'd1) : v;
	endfunction

	function automatic logic [31:0] sat32(input logic [35:0] v);
		if (!v[35] && v[34:31] != 4'h0) begin
			return 32'h7FFF_FFFF;
		end else if (v[35] && v[34:31] != 4'hF) begin
			return 32'h8000_0000;
		end
		return v[31:0];
	endfunction

	state_t             state_q;
	logic               issued_q;
	logic [1:0]         ax_q;
	logic               bd_q;
	logic signed [31:0] cp_q [3];
	logic signed [31:0] op_q [3];
	logic signed [31:0] cv_q [3];
	logic signed [31:0] ov_q [3];
	logic [15:0]        dt_q;
	logic [31:0]        mc_q;
	logic [31:0]        mo_q;
	logic               result_valid_q;

	logic               load_q;
	logic [32:0]        r_q [3];
	logic [31:0]        ldc_q [3];
	logic [31:0]        ldo_q [3];
	logic [31:0]        d_q;
	logic [127:0]       den_q;
	logic [67:0]        gmt_q [2];
	result_t            result_q;

	alu_ctl_t     ctl;
	alu_sts_t     sts;
	logic [127:0] opa;
	logic [191:0] opb;
	logic [127:0] alu_res;

	logic [32:0] rmag;
	logic [31:0] mass_sel;
	logic        sum_big;
	logic [31:0] vsel;
	logic [31:0] psel;
	logic [31:0] vmag;
	logic [33:0] dvmag;
	logic        dv_neg;
	logic [31:0] vnew;
	logic [31:0] pnew;
	logic [31:0] mv;
	logic [31:0] spd;
	logic [31:0] spd_sat;
	logic [35:0] dv_ext;
	logic [35:0] mv_ext;

	tbgs_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.opa    (opa),
		.opb    (opb),
		.sts    (sts),
		.res    (alu_res)
	);

	// Per-axis, per-body selections and the velocity and position updates.
	always_comb begin
		rmag     = mag33(r_q[ax_q]);
		mass_sel = bd_q ? mo_q : mc_q;
		sum_big  = alu_res[127:64] != 64'b0;
		vsel     = bd_q ? cv_q[ax_q] : ov_q[ax_q];
		psel     = bd_q ? cp_q[ax_q] : op_q[ax_q];
		vmag     = vsel[31] ? (~vsel + 32'd1) : vsel;
		if (sts.ovf || alu_res[63:0] > {30'b0, DV_CAP}) begin
			dvmag = DV_CAP;
		end else begin
			dvmag = alu_res[33:0];
		end
		dv_neg  = bd_q ? ~r_q[ax_q][32] : r_q[ax_q][32];
		dv_ext  = dv_neg ? (~{2'b0, dvmag} + 36'd1) : {2'b0, dvmag};
		vnew    = sat32({{4{vsel[31]}}, vsel} + dv_ext);
		mv      = alu_res[47:16];
		mv_ext  = vsel[31] ? (~{4'b0, mv} + 36'd1) : {4'b0, mv};
		pnew    = sat32({{4{psel[31]}}, psel} + mv_ext);
		spd     = alu_res[47:16];
		spd_sat = spd[31] ? 32'h7FFF_FFFF : spd;
	end

	// Operation issued to the shared unit in each step of the sequence.
	always_comb begin
		ctl       = '0;
		ctl.op    = ALU_MUL;
		ctl.start = !issued_q;
		opa       = '0;
		opb       = '0;
		case (state_q)
			S_SQ: begin
				ctl.accum = ax_q != 2'd0;
				ctl.steps = 8'd33;
				opa       = {95'b0, rmag};
				opb       = {159'b0, rmag};
			end
			S_ROOT: begin
				ctl.op    = ALU_SQRT;
				ctl.steps = 8'd32;
				ctl.start = !issued_q && !sum_big;
				opa       = alu_res;
			end
			S_GM: begin
				ctl.steps = 8'd20;
				opa       = {96'b0, mass_sel};
				opb       = {172'b0, GRAV_Q16};
			end
			S_SDIV: begin
				ctl.op    = ALU_DIV;
				ctl.steps = 8'd65;
				opa       = alu_res << SPD_SH;
				opb       = {96'b0, d_q, 64'b0};
			end
			S_SROOT: begin
				ctl.op    = ALU_SQRT;
				ctl.steps = 8'd32;
				opa       = {64'b0, sts.ovf ? 64'hFFFF_FFFF_FFFF_FFFF : alu_res[63:0]};
			end
			S_SK: begin
				ctl.steps = 8'd16;
				opa       = {96'b0, alu_res[31:0]};
				opb       = {176'b0, SPEED_K_Q16};
			end
			S_DD: begin
				ctl.steps = 8'd32;
				opa       = {96'b0, d_q};
				opb       = {160'b0, d_q};
			end
			S_DDD: begin
				ctl.steps = 8'd32;
				opa       = {64'b0, alu_res[63:0]};
				opb       = {160'b0, d_q};
			end
			S_GMT: begin
				ctl.steps = 8'd16;
				opa       = {76'b0, alu_res[51:0]};
				opb       = {176'b0, dt_q};
			end
			S_MR: begin
				ctl.steps = 8'd33;
				opa       = {60'b0, gmt_q[bd_q]};
				opb       = {159'b0, rmag};
			end
			S_DIV: begin
				ctl.op    = ALU_DIV;
				ctl.steps = 8'd35;
				opa       = alu_res << DVN_SH;
				opb       = {30'b0, den_q, 34'b0};
			end
			S_ADV: begin
				ctl.steps = 8'd16;
				opa       = {96'b0, vmag};
				opb       = {176'b0, dt_q};
			end
			default: begin
				ctl.start = 1'b0;
			end
		endcase
	end

	// Sequencer, body state and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			issued_q       <= 1'b0;
			ax_q           <= '0;
			bd_q           <= 1'b0;
			dt_q           <= TIME_STEP_RST;
			mc_q           <= MASS_RST;
			mo_q           <= MASS_RST;
			result_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cp_q[i] <= '0;
				op_q[i] <= '0;
				cv_q[i] <= '0;
				ov_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_TIME_STEP:     dt_q <= cfg_data[15:0];
					CFG_CENTRAL_MASS:  mc_q <= cfg_data;
					CFG_ORBITING_MASS: mo_q <= cfg_data;
					default: ;
				endcase
			end
			// The output register fills from S_OUT and empties on a result transfer.
			if (state_q == S_OUT && (!result_valid_q || result_ready)) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (ctl.start) begin
				issued_q <= 1'b1;
			end else if (sts.done) begin
				issued_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						ax_q    <= '0;
						bd_q    <= 1'b0;
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (sts.done) begin
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							state_q <= S_ROOT;
						end else begin
							ax_q <= ax_q + 2'd1;
						end
					end
				end
				S_ROOT: begin
					if ((!issued_q && sum_big) || sts.done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (d_q == 32'd0) begin
						state_q <= S_OUT;
					end else if (load_q) begin
						for (int i = 0; i < 3; i++) begin
							cp_q[i] <= ldc_q[i];
							op_q[i] <= ldo_q[i];
							cv_q[i] <= '0;
							ov_q[i] <= '0;
						end
						state_q <= S_GM;
					end else begin
						state_q <= S_DD;
					end
				end
				S_GM: begin
					if (sts.done) begin
						state_q <= load_q ? S_SDIV : S_GMT;
					end
				end
				S_SDIV: begin
					if (sts.done) begin
						state_q <= S_SROOT;
					end
				end
				S_SROOT: begin
					if (sts.done) begin
						state_q <= S_SK;
					end
				end
				S_SK: begin
					if (sts.done) begin
						if (!bd_q) begin
							ov_q[2] <= spd_sat;
							bd_q    <= 1'b1;
							state_q <= S_GM;
						end else begin
							cv_q[2] <= ~spd_sat + 32'd1;
							bd_q    <= 1'b0;
							state_q <= S_OUT;
						end
					end
				end
				S_DD: begin
					if (sts.done) begin
						state_q <= S_DDD;
					end
				end
				S_DDD: begin
					if (sts.done) begin
						state_q <= S_GM;
					end
				end
				S_GMT: begin
					if (sts.done) begin
						if (!bd_q) begin
							bd_q    <= 1'b1;
							state_q <= S_GM;
						end else begin
							bd_q    <= 1'b0;
							ax_q    <= '0;
							state_q <= S_MR;
						end
					end
				end
				S_MR: begin
					if (sts.done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (sts.done) begin
						if (bd_q) begin
							cv_q[ax_q] <= vnew;
						end else begin
							ov_q[ax_q] <= vnew;
						end
						state_q <= S_ADV;
					end
				end
				S_ADV: begin
					if (sts.done) begin
						if (bd_q) begin
							cp_q[ax_q] <= pnew;
						end else begin
							op_q[ax_q] <= pnew;
						end
						if (!bd_q) begin
							bd_q    <= 1'b1;
							state_q <= S_MR;
						end else begin
							bd_q <= 1'b0;
							if (ax_q == 2'd2) begin
								ax_q    <= '0;
								state_q <= S_OUT;
							end else begin
								ax_q    <= ax_q + 2'd1;
								state_q <= S_MR;
							end
						end
					end
				end
				S_OUT: begin
					if (!result_valid_q || result_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Item operands, intermediate results and the output register.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			load_q   <= item.command == CMD_LOAD;
			ldc_q[0] <= item.central_x;
			ldc_q[1] <= item.central_y;
			ldc_q[2] <= item.central_z;
			ldo_q[0] <= item.orbiting_x;
			ldo_q[1] <= item.orbiting_y;
			ldo_q[2] <= item.orbiting_z;
			if (item.command == CMD_STEP) begin
				for (int i = 0; i < 3; i++) begin
					r_q[i] <= {cp_q[i][31], cp_q[i]} - {op_q[i][31], op_q[i]};
				end
			end else begin
				r_q[0] <= {item.central_x[31], item.central_x}
					- {item.orbiting_x[31], item.orbiting_x};
				r_q[1] <= {item.central_y[31], item.central_y}
					- {item.orbiting_y[31], item.orbiting_y};
				r_q[2] <= {item.central_z[31], item.central_z}
					- {item.orbiting_z[31], item.orbiting_z};
			end
		end
		if (state_q == S_ROOT) begin
			if (!issued_q && sum_big) begin
				d_q <= 32'hFFFF_FFFF;
			end else if (sts.done) begin
				d_q <= alu_res[31:0];
			end
		end
		if (state_q == S_DDD && sts.done) begin
			den_q <= {32'b0, alu_res[95:0]} << DVD_SH;
		end
		if (state_q == S_GMT && sts.done) begin
			gmt_q[bd_q] <= alu_res[67:0];
		end
		if (state_q == S_OUT && (!result_valid_q || result_ready)) begin
			result_q.central_pos_x  <= cp_q[0];
			result_q.central_pos_y  <= cp_q[1];
			result_q.central_pos_z  <= cp_q[2];
			result_q.orbiting_pos_x <= op_q[0];
			result_q.orbiting_pos_y <= op_q[1];
			result_q.orbiting_pos_z <= op_q[2];
			result_q.separation     <= d_q;
			result_q.degenerate     <= d_q == 32'd0;
		end
	end

	assign item_ready   = state_q == S_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	property p_deg_zero_sep;
		@(posedge clk) disable iff (!arst_n)
			result_valid && result.degenerate |-> result.separation == 32'd0;
	endproperty
	a_deg_zero_sep: assert property (p_deg_zero_sep)
		else $error("degenerate result with nonzero separation");

	property p_accept_starts;
		@(posedge clk) disable iff (!arst_n) item_valid && item_ready |=> state_q == S_SQ;
	endproperty
	a_accept_starts: assert property (p_accept_starts)
		else $error("accepted item did not start the sequence");

	property p_no_done_idle;
		@(posedge clk) disable iff (!arst_n) sts.done |-> state_q != S_IDLE;
	endproperty
	a_no_done_idle: assert property (p_no_done_idle)
		else $error("shared unit finished with no item in work");

	property p_axis_range;
		@(posedge clk) disable iff (!arst_n) ax_q != 2'd3;
	endproperty
	a_axis_range: assert property (p_axis_range)
		else $error("axis counter out of range");

endmodule
